[hdl/sptdp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sptdp_pkg
// Shared types and constants of the segment/page translator with demand paging.
// ----------------------------------------------------------------------------
package sptdp_pkg;

	// default geometry
	localparam int NUM_FRAMES_DEF  = 1024;
	localparam int FRAME_WORDS_DEF = 512;
	localparam int DISK_BLOCKS_DEF = 1024;

	// segment table occupies words 0 .. SEG_TABLE_WORDS-1
	localparam int SEG_TABLE_WORDS = 512;

	// fixed field widths
	localparam int OP_W     = 2;
	localparam int VA_W     = 27;
	localparam int IDX_W    = 9;
	localparam int ENTRY_W  = 20;
	localparam int PA_W     = 19;
	localparam int STATUS_W = 2;
	localparam int LOADED_W = 2;

	// virtual address split
	localparam int VA_SEG_LSB  = 18;
	localparam int VA_PAGE_LSB = 9;

	// item codes
	localparam logic [OP_W-1:0] OP_LOAD_SEG  = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_PAGE = 2'd1;
	localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STS_INVALID  = 2'd1;
	localparam logic [STATUS_W-1:0] STS_DISK     = 2'd2;
	localparam logic [STATUS_W-1:0] STS_NO_FRAME = 2'd3;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SEG_DIV,
		S_SEG_FIX,
		S_PG_WR,
		S_TR_SEG,
		S_TR_PG_RD,
		S_TR_PG,
		S_COPY,
		S_TR_UPD,
		S_DONE
	} state_t;

endpackage

[hdl/sptdp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sptdp_ram
// Generic single-port synchronous RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module sptdp_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[hdl/segment_page_translate_demand_paging_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_page_translate_demand_paging_unit
// Two-level segment/page translator over one word-addressed memory, with
// optional loading of disk blocks into free frames on a fault.
// ----------------------------------------------------------------------------
// All tables and frames live in a single-port RAM of NUM_FRAMES*FRAME_WORDS
// words with a registered read, so every item is a short sequence of RAM
// accesses and one item is worked on at a time. After reset the RAM is swept
// to -1, one word a cycle, over all NUM_FRAMES*FRAME_WORDS words (524288 at the
// defaults); in_ready stays low during the sweep while configuration beats are
// taken. A translate hit reads the segment entry, then the page-table entry,
// then gives the result; a segment-entry load also runs a reciprocal multiply
// for the frame number. Every disk block brought in on a fault is copied into
// its frame one word a cycle through the RAM port. A finished result waits in
// the output register while the next item is accepted.
module segment_page_translate_demand_paging_unit
	import sptdp_pkg::*;
#(
	parameter int NUM_FRAMES  = NUM_FRAMES_DEF,
	parameter int FRAME_WORDS = FRAME_WORDS_DEF,
	parameter int DISK_BLOCKS = DISK_BLOCKS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       demand_paging,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [OP_W-1:0]            op,
	input  logic [VA_W-1:0]            virtual_address,
	input  logic [IDX_W-1:0]           segment_index,
	input  logic [IDX_W-1:0]           page_index,
	input  logic signed [ENTRY_W-1:0]  entry_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [PA_W-1:0]            physical_address,
	output logic [STATUS_W-1:0]        status,
	output logic [LOADED_W-1:0]        blocks_loaded
);

	localparam int MEM_WORDS = NUM_FRAMES * FRAME_WORDS;
	localparam int AW        = $clog2(MEM_WORDS);
	localparam int BLK_WORDS = DISK_BLOCKS * FRAME_WORDS;
	localparam int VMAX0     = (MEM_WORDS > BLK_WORDS) ? MEM_WORDS : BLK_WORDS;
	localparam int VMAX      = (VMAX0 > (1 << PA_W)) ? VMAX0 : (1 << PA_W);
	// stored word: sign plus magnitude of any address or block word
	localparam int DW        = $clog2(VMAX) + 1;
	localparam int FRB       = $clog2(NUM_FRAMES);
	localparam int FB        = $clog2(NUM_FRAMES + 1);
	localparam int AFB       = (FB > 6) ? FB : 6;
	localparam int BLKB      = $clog2(DISK_BLOCKS);
	localparam int CNTB      = $clog2(FRAME_WORDS);
	localparam int ST_FRAMES = (SEG_TABLE_WORDS + FRAME_WORDS - 1) / FRAME_WORDS;
	localparam int MAG_W     = ENTRY_W - 1;
	// reciprocal of FRAME_WORDS, quotient estimate is low by at most one
	localparam int RECIP_SHIFT = ENTRY_W + CNTB;
	localparam int RECIP_W     = 21;
	localparam logic [63:0] RECIP = (64'd1 << RECIP_SHIFT) / FRAME_WORDS;
	localparam int MUL_W       = MAG_W + RECIP_W;
	localparam logic [DW-1:0] MEM_LIMIT = DW'(MEM_WORDS);

	state_t state_q, state_d;

	logic [AW-1:0]        clr_addr_q;
	logic                 demand_q;
	logic [FB-1:0]        next_free_q;

	logic [IDX_W-1:0]     seg_q;
	logic [IDX_W-1:0]     page_q;
	logic [IDX_W-1:0]     off_q;
	logic signed [ENTRY_W-1:0] entry_q;
	logic                 rd_oob_q;
	logic [MUL_W-1:0]     mul_s1;
	logic [MAG_W-1:0]     qest_s2;
	logic [ENTRY_W-1:0]   qprod_s2;
	logic [FRB-1:0]       fr_q;
	logic [DW-1:0]        pt_addr_q;
	logic [AW-1:0]        cp_addr_q;
	logic [DW-1:0]        cp_val_q;
	logic [CNTB-1:0]      cp_cnt_q;
	logic                 pass_q;
	logic [LOADED_W-1:0]  loaded_q;
	logic [PA_W-1:0]      res_pa_q;
	logic [STATUS_W-1:0]  res_status_q;
	logic                 out_valid_q;
	logic [PA_W-1:0]      pa_q;
	logic [STATUS_W-1:0]  status_q;
	logic [LOADED_W-1:0]  blocks_q;

	logic                 mem_we;
	logic [AW-1:0]        mem_addr;
	logic [DW-1:0]        mem_wdata;
	logic [DW-1:0]        mem_rdata;
	logic                 rd_oob_d;

	logic                 in_accept;
	logic                 out_free;
	logic                 fin;
	logic [PA_W-1:0]      fin_pa;
	logic [STATUS_W-1:0]  fin_status;

	logic [IDX_W-1:0]     seg_in;
	logic                 seg_in_ok;
	logic                 seg_q_ok;
	logic [DW-1:0]        rd_val;
	logic                 rd_neg;
	logic                 rd_invalid;
	logic [DW-1:0]        pt_addr_c;
	logic                 pt_addr_ok;
	logic                 pt_addr_q_ok;
	logic                 pe_frame_ok;
	logic [DW-1:0]        pa_pe_full;
	logic [DW-1:0]        pa_fr_full;
	logic [DW:0]          flt_block;
	logic                 flt_block_ok;
	logic [AFB-1:0]       alloc_c;
	logic                 alloc_fail;
	logic [STATUS_W-1:0]  flt_status;
	logic                 flt_start;
	logic [AW-1:0]        flt_base_addr;
	logic [DW-1:0]        flt_val0;
	logic [DW-1:0]        fr_base;
	logic [MAG_W-1:0]     qest_c;
	logic [ENTRY_W-1:0]   qprod_c;
	logic [ENTRY_W-1:0]   seg_rem;
	logic [MAG_W-1:0]     seg_frame;
	logic                 seg_raise;
	logic                 pg_raise;

	sptdp_ram #(
		.WIDTH (DW),
		.DEPTH (MEM_WORDS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_accept = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign out_valid        = out_valid_q;
	assign physical_address = pa_q;
	assign status           = status_q;
	assign blocks_loaded    = blocks_q;

	assign seg_in    = (op == OP_TRANSLATE) ? virtual_address[VA_SEG_LSB +: IDX_W]
		: segment_index;
	assign seg_in_ok = DW'(seg_in) < MEM_LIMIT;
	assign seg_q_ok  = DW'(seg_q) < MEM_LIMIT;

	// a read beyond the memory returns an invalid entry
	assign rd_val     = rd_oob_q ? '1 : mem_rdata;
	assign rd_neg     = rd_val[DW-1];
	assign rd_invalid = &rd_val;

	assign pt_addr_c    = rd_val + DW'(page_q);
	assign pt_addr_ok   = pt_addr_c < MEM_LIMIT;
	assign pt_addr_q_ok = pt_addr_q < MEM_LIMIT;
	assign pe_frame_ok  = !rd_neg && (rd_val < DW'(NUM_FRAMES));
	assign pa_pe_full   = rd_val * DW'(FRAME_WORDS) + DW'(off_q);
	assign fr_base      = DW'(fr_q) * DW'(FRAME_WORDS);
	assign pa_fr_full   = fr_base + DW'(off_q);

	// fault resolution of the entry just read
	assign flt_block    = (DW + 1)'(0) - {rd_val[DW-1], rd_val};
	assign flt_block_ok = flt_block < (DW + 1)'(DISK_BLOCKS);
	assign alloc_c      = (AFB'(next_free_q) < AFB'(ST_FRAMES)) ? AFB'(ST_FRAMES)
		: AFB'(next_free_q);
	assign alloc_fail   = alloc_c >= AFB'(NUM_FRAMES);
	assign flt_base_addr = AW'(alloc_c[FRB-1:0]) * AW'(FRAME_WORDS);
	assign flt_val0      = DW'(flt_block[BLKB-1:0]) * DW'(FRAME_WORDS);

	always_comb begin
		priority if (!demand_q) begin
			flt_status = STS_DISK;
		end else if (!flt_block_ok) begin
			flt_status = STS_INVALID;
		end else if (alloc_fail) begin
			flt_status = STS_NO_FRAME;
		end else begin
			flt_status = STS_OK;
		end
	end

	assign flt_start = ((state_q == S_TR_SEG) || (state_q == S_TR_PG)) && rd_neg &&
		!rd_invalid && (flt_status == STS_OK);

	// frame number of a segment base: reciprocal estimate, then one correction
	assign qest_c    = MAG_W'(mul_s1 >> RECIP_SHIFT);
	assign qprod_c   = ENTRY_W'(ENTRY_W'(qest_c) * ENTRY_W'(FRAME_WORDS));
	assign seg_rem   = {1'b0, entry_q[MAG_W-1:0]} - qprod_s2;
	assign seg_frame = qest_s2 + MAG_W'(seg_rem >= ENTRY_W'(FRAME_WORDS));
	assign seg_raise = !entry_q[ENTRY_W-1] && (seg_frame < MAG_W'(NUM_FRAMES)) &&
		(seg_frame >= MAG_W'(next_free_q));
	assign pg_raise  = !entry_q[ENTRY_W-1] &&
		(entry_q[MAG_W-1:0] < MAG_W'(NUM_FRAMES)) &&
		(entry_q[MAG_W-1:0] >= MAG_W'(next_free_q));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_addr_q == AW'(MEM_WORDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					unique case (op)
						OP_LOAD_SEG:  state_d = S_SEG_DIV;
						OP_LOAD_PAGE: state_d = S_PG_WR;
						OP_TRANSLATE: state_d = S_TR_SEG;
						default:      state_d = S_DONE;
					endcase
				end
			end
			S_SEG_DIV:  state_d = S_SEG_FIX;
			S_SEG_FIX:  state_d = S_DONE;
			S_PG_WR:    state_d = S_DONE;
			S_TR_SEG: begin
				priority if (rd_invalid) begin
					state_d = S_DONE;
				end else if (rd_neg) begin
					state_d = (flt_status == STS_OK) ? S_COPY : S_DONE;
				end else begin
					state_d = S_TR_PG;
				end
			end
			S_TR_PG_RD: state_d = S_TR_PG;
			S_TR_PG: begin
				if (flt_start) begin
					state_d = S_COPY;
				end else begin
					state_d = out_free ? S_IDLE : S_DONE;
				end
			end
			S_COPY: begin
				if (cp_cnt_q == CNTB'(FRAME_WORDS - 1)) begin
					state_d = S_TR_UPD;
				end
			end
			S_TR_UPD: begin
				if (!pass_q) begin
					state_d = S_TR_PG_RD;
				end else begin
					state_d = out_free ? S_IDLE : S_DONE;
				end
			end
			S_DONE:     state_d = out_free ? S_IDLE : S_DONE;
			default:    state_d = S_IDLE;
		endcase
	end

	// memory port and result
	always_comb begin
		mem_we     = 1'b0;
		mem_addr   = '0;
		mem_wdata  = '0;
		rd_oob_d   = 1'b0;
		fin        = 1'b0;
		fin_pa     = '0;
		fin_status = STS_OK;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_addr_q;
				mem_wdata = '1;
			end
			S_IDLE: begin
				if (in_valid) begin
					mem_addr = AW'(seg_in);
					if (op == OP_LOAD_SEG) begin
						mem_we    = seg_in_ok;
						mem_wdata = DW'(entry_value);
					end else begin
						rd_oob_d = !seg_in_ok;
					end
				end
			end
			S_PG_WR: begin
				if (!rd_neg) begin
					mem_we    = pt_addr_ok;
					mem_addr  = pt_addr_c[AW-1:0];
					mem_wdata = DW'(entry_q);
				end
			end
			S_TR_SEG: begin
				if (!rd_neg) begin
					mem_addr = pt_addr_c[AW-1:0];
					rd_oob_d = !pt_addr_ok;
				end
			end
			S_TR_PG_RD: begin
				mem_addr = pt_addr_q[AW-1:0];
				rd_oob_d = !pt_addr_q_ok;
			end
			S_TR_PG: begin
				fin = !flt_start;
				priority if (rd_invalid) begin
					fin_status = STS_INVALID;
				end else if (rd_neg) begin
					fin_status = flt_status;
				end else if (!pe_frame_ok) begin
					fin_status = STS_INVALID;
				end else begin
					fin_pa = pa_pe_full[PA_W-1:0];
				end
			end
			S_COPY: begin
				mem_we    = 1'b1;
				mem_addr  = cp_addr_q;
				mem_wdata = cp_val_q;
			end
			S_TR_UPD: begin
				if (!pass_q) begin
					mem_we    = seg_q_ok;
					mem_addr  = AW'(seg_q);
					mem_wdata = fr_base;
				end else begin
					mem_we    = pt_addr_q_ok;
					mem_addr  = pt_addr_q[AW-1:0];
					mem_wdata = DW'(fr_q);
					fin       = 1'b1;
					fin_pa    = pa_fr_full[PA_W-1:0];
				end
			end
			S_DONE: begin
				fin        = 1'b1;
				fin_pa     = res_pa_q;
				fin_status = res_status_q;
			end
			S_SEG_DIV, S_SEG_FIX: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			demand_q    <= 1'b0;
			next_free_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (cfg_valid) begin
				demand_q <= demand_paging;
			end
			if (state_q == S_SEG_FIX && seg_raise) begin
				next_free_q <= FB'(seg_frame + MAG_W'(1));
			end else if (state_q == S_PG_WR && !rd_neg && pg_raise) begin
				next_free_q <= FB'(entry_q[MAG_W-1:0] + MAG_W'(1));
			end else if (flt_start) begin
				next_free_q <= FB'(alloc_c + AFB'(1));
			end
			if (fin && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_oob_q <= rd_oob_d;
		if (in_accept) begin
			seg_q        <= seg_in;
			page_q       <= (op == OP_TRANSLATE) ? virtual_address[VA_PAGE_LSB +: IDX_W]
				: page_index;
			off_q        <= virtual_address[IDX_W-1:0];
			entry_q      <= entry_value;
			mul_s1       <= MUL_W'(entry_value[MAG_W-1:0]) * MUL_W'(RECIP[RECIP_W-1:0]);
			loaded_q     <= '0;
			res_pa_q     <= '0;
			res_status_q <= STS_OK;
		end
		if (state_q == S_SEG_DIV) begin
			qest_s2  <= qest_c;
			qprod_s2 <= qprod_c;
		end
		if (state_q == S_TR_SEG) begin
			if (!rd_neg) begin
				pt_addr_q <= pt_addr_c;
			end
			if (rd_invalid) begin
				res_status_q <= STS_INVALID;
			end else if (rd_neg) begin
				res_status_q <= flt_status;
			end
		end
		if (flt_start) begin
			fr_q      <= alloc_c[FRB-1:0];
			cp_addr_q <= flt_base_addr;
			cp_val_q  <= flt_val0;
			cp_cnt_q  <= '0;
			loaded_q  <= loaded_q + LOADED_W'(1);
			pass_q    <= (state_q == S_TR_PG);
		end
		if (state_q == S_COPY) begin
			cp_addr_q <= cp_addr_q + AW'(1);
			cp_val_q  <= cp_val_q + DW'(1);
			cp_cnt_q  <= cp_cnt_q + CNTB'(1);
		end
		if (state_q == S_TR_UPD && !pass_q) begin
			pt_addr_q <= fr_base + DW'(page_q);
		end
		if (fin) begin
			if (out_free) begin
				pa_q     <= fin_pa;
				status_q <= fin_status;
				blocks_q <= loaded_q;
			end else begin
				res_pa_q     <= fin_pa;
				res_status_q <= fin_status;
			end
		end
	end

`ifndef ASSERT_OFF
	a_next_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= FB'(NUM_FRAMES))
		else $error("next free frame beyond frame count");

	a_error_no_address: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STS_OK) |-> (physical_address == '0))
		else $error("failed translation carries an address");

	a_fault_copies: assert property (@(posedge clk) disable iff (!arst_n)
		flt_start |=> (state_q == S_COPY))
		else $error("allocated frame not filled");
`endif

endmodule
